/* rtl/channel_list_parser_assert.svh */
// Assertion macros for the channel list parser.
// Needs clk and rst in the scope where the macros are used.
`ifndef CHANNEL_LIST_PARSER_ASSERT_SVH
`define CHANNEL_LIST_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/clp_pkg.sv */
// Shared types and constants for the channel list parser.
// No dependencies.
package clp_pkg;

  localparam int MAX_TOKEN_CHARS = 8;
  localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
  localparam logic [LEN_W-1:0] MAX_TOKEN_LEN = LEN_W'(MAX_TOKEN_CHARS);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [3:0] RADIX    = 4'd10;

  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_MAX_OUT       = 1'b1;
  localparam logic [7:0] CHANNEL_COUNT_RESET = 8'd0;
  localparam logic [7:0] MAX_OUT_RESET       = 8'd255;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_KEPT,
    KIND_DROPPED,
    KIND_INVALID,
    KIND_SUMMARY
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] index;
    logic [7:0] kept_count;
    logic       invalid_seen;
    logic       last;
  } res_t;

  typedef struct packed {
    logic             started;
    logic             space_pending;
    logic [LEN_W-1:0] length;
    logic [7:0]       value;
    logic             bad;
    logic [7:0]       written_count;
    logic             invalid_flag;
  } parse_state_t;

endpackage

/* rtl/clp_token.sv */
// Per-byte parser step: next state and up to two results for one byte.
// Depends on clp_pkg.
module clp_token (
  input  clp_pkg::parse_state_t st,
  input  logic [7:0]            ch,
  input  logic [7:0]            channel_count,
  input  logic [7:0]            max_out,
  output clp_pkg::parse_state_t st_next,
  output clp_pkg::res_t         res0,
  output clp_pkg::res_t         res1,
  output logic [1:0]            n_res
);
  import clp_pkg::*;

  logic             tok_has;
  logic             tok_ok;
  res_t             tok_res;
  res_t             summary;
  logic [7:0]       wc_after;
  logic             inv_after;
  logic             is_digit;
  logic             bad_a;
  logic [LEN_W-1:0] len_a;
  logic [11:0]      acc;

  // Closing the open token
  always_comb begin
    tok_has   = st.started && (max_out != 8'd0);
    tok_ok    = !st.bad && (st.length < MAX_TOKEN_LEN);
    wc_after  = st.written_count;
    inv_after = st.invalid_flag;
    tok_res   = '0;
    if (tok_ok) begin
      tok_res.index = st.value;
      if (st.written_count < max_out) begin
        tok_res.kind = KIND_KEPT;
        if (tok_has) begin
          wc_after = st.written_count + 8'd1;
        end
      end else begin
        tok_res.kind = KIND_DROPPED;
      end
    end else begin
      tok_res.kind = KIND_INVALID;
      if (tok_has) begin
        inv_after = 1'b1;
      end
    end
    tok_res.kept_count   = wc_after;
    tok_res.invalid_seen = inv_after;

    summary      = '0;
    summary.kind = KIND_SUMMARY;
    summary.last = 1'b1;
    if (max_out != 8'd0) begin
      summary.kept_count   = wc_after;
      summary.invalid_seen = inv_after;
    end
  end

  // Byte classification and accumulate
  always_comb begin
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    bad_a    = st.bad || st.space_pending;
    len_a    = st.length;
    if (st.space_pending && (st.length < MAX_TOKEN_LEN)) begin
      len_a = st.length + LEN_W'(1);
    end
    acc = 12'(st.value) * 12'(RADIX) + 12'(ch - CH_ZERO);
  end

  always_comb begin
    st_next = st;
    res0    = tok_res;
    res1    = summary;
    n_res   = 2'd0;
    priority if (ch == CH_NUL) begin
      if (tok_has) begin
        n_res = 2'd2;
      end else begin
        res0  = summary;
        n_res = 2'd1;
      end
      st_next = '0;
    end else if (ch == CH_COMMA) begin
      n_res                 = tok_has ? 2'd1 : 2'd0;
      st_next               = '0;
      st_next.written_count = wc_after;
      st_next.invalid_flag  = inv_after;
    end else if (ch == CH_SPACE) begin
      if (st.started) begin
        st_next.space_pending = 1'b1;
      end
    end else begin
      st_next.started       = 1'b1;
      st_next.space_pending = 1'b0;
      st_next.bad           = bad_a;
      st_next.length        = len_a;
      if (len_a < MAX_TOKEN_LEN) begin
        st_next.length = len_a + LEN_W'(1);
      end
      if (!is_digit) begin
        st_next.bad = 1'b1;
      end else if (!bad_a) begin
        if (acc >= 12'(channel_count)) begin
          st_next.bad = 1'b1;
        end else begin
          st_next.value = acc[7:0];
        end
      end
    end
  end

endmodule

/* rtl/clp_fifo.sv */
// Small result queue: takes up to two results a cycle, gives one.
// Depends on clp_pkg.
module clp_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   push_n,
  input  clp_pkg::res_t                d0,
  input  clp_pkg::res_t                d1,
  input  logic                         pop,
  output clp_pkg::res_t                head,
  output logic [clp_pkg::FIFO_CW-1:0]  count
);
  import clp_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr + FIFO_AW'(1);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= d0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

endmodule

/* rtl/channel_list_parser.sv */
// Channel list parser, top level.
// Depends on clp_pkg, clp_token, clp_fifo and channel_list_parser_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, ch): one string byte per request.
//   A byte 0 ends the string; ',' separates tokens; spaces around a token
//   are trimmed, a space inside a token makes it invalid.
//   Output channel (out_valid/out_ready): one result per request, with kind
//   kept/dropped/invalid at each nonempty token end if max_out > 0, and an
//   end summary (last = 1) after byte 0. Byte 0 behind an open token gives both.
//   Configuration: cfg_we, cfg_index, cfg_data; 0 = channel_count,
//   1 = max_out. Write only while the block is idle.
// Timing:
//   A byte is parsed in the cycle it is accepted; its results sit in the
//   result queue from the next cycle, where out_valid shows them.
//   One byte a cycle is accepted while the queue has two free slots; a
//   byte that yields two results is drained one result per output
//   transfer, so the output port sets the rate at string ends.
// Reset: clears the parse state and the queue; channel_count goes to 0 and
//   max_out to 255.
// Stall: when out_ready is low the queue holds results and in_ready drops
//   once fewer than two slots are free.
module channel_list_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] index,
  output logic [7:0] kept_count,
  output logic       invalid_seen,
  output logic       last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import clp_pkg::*;

  `include "channel_list_parser_assert.svh"

  logic [7:0]         channel_count;
  logic [7:0]         max_out;
  parse_state_t       pstate;
  parse_state_t       pstate_next;
  res_t               res0;
  res_t               res1;
  logic [1:0]         n_res;
  logic [1:0]         push_n;
  res_t               head;
  logic [FIFO_CW-1:0] count;
  logic               in_fire;
  logic               out_fire;

  // Two free slots guarantee room for the worst-case byte.
  assign in_ready  = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_fire  = out_valid && out_ready;
  assign push_n    = in_fire ? n_res : 2'd0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RESET;
      max_out       <= MAX_OUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data;
        CFG_MAX_OUT:       max_out       <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Parse state advances only on an accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= '0;
    end else if (in_fire) begin
      pstate <= pstate_next;
    end
  end

  clp_token u_token (
    .st            (pstate),
    .ch            (ch),
    .channel_count (channel_count),
    .max_out       (max_out),
    .st_next       (pstate_next),
    .res0          (res0),
    .res1          (res1),
    .n_res         (n_res)
  );

  clp_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .d0     (res0),
    .d1     (res1),
    .pop    (out_fire),
    .head   (head),
    .count  (count)
  );

  assign kind         = head.kind;
  assign index        = head.index;
  assign kept_count   = head.kept_count;
  assign invalid_seen = head.invalid_seen;
  assign last         = head.last;

  // Checks
  `CLP_ASSERT_NOW(a_queue_bound, 1'b1, count <= FIFO_CW'(FIFO_DEPTH),
    "result queue overfilled")
  `CLP_ASSERT_NEXT(a_string_end_clears, in_fire && (ch == CH_NUL),
    pstate.written_count == 8'd0 && !pstate.invalid_flag && !pstate.started,
    "string state not cleared after end byte")
  `CLP_ASSERT_NEXT(a_invalid_sticky, in_fire && (ch != CH_NUL) && pstate.invalid_flag,
    pstate.invalid_flag, "invalid flag lost within a string")
  `CLP_ASSERT_NOW(a_last_is_summary, out_valid && last, kind == KIND_SUMMARY,
    "last set on a non-summary result")

endmodule
